/* rtl/odrc_pkg.sv */
// ----------------------------------------------------------------------------
// odrc_pkg: shared types and constants of the divider and ratio calculator
// Holds field widths, register indexes, status codes and speed-divider tables.
// ----------------------------------------------------------------------------
package odrc_pkg;

  localparam int FRAC_BITS_DEF = 20;
  localparam int REG_W   = 48;
  localparam int FREQ_W  = 31;
  localparam int DCO_W   = 13;
  localparam int RATIO_W = 38;
  localparam int CFG_W   = 31;
  localparam int CFG_IDX_W = 2;
  localparam logic [10:0] MAX_TOTAL_DIV = 11'd1408;

  localparam logic [CFG_IDX_W-1:0] CFG_CUR_FREQ = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DCO_MAX  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DCO_MIN  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_DIV   = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // Speed divider value of a register code
  function automatic logic [3:0] hs_of_code(input logic [2:0] c);
    logic [3:0] v;
    case (c)
      3'd0: v = 4'd4;
      3'd1: v = 4'd5;
      3'd2: v = 4'd6;
      3'd3: v = 4'd7;
      3'd4: v = 4'd4;
      3'd5: v = 4'd9;
      3'd6: v = 4'd6;
      3'd7: v = 4'd11;
      default: v = 4'd4;
    endcase
    return v;
  endfunction

  // Register code of a speed divider value
  function automatic logic [2:0] code_of_hs(input logic [3:0] v);
    logic [2:0] c;
    case (v)
      4'd5:  c = 3'd1;
      4'd6:  c = 3'd2;
      4'd7:  c = 3'd3;
      4'd9:  c = 3'd5;
      4'd11: c = 3'd7;
      default: c = 3'd0;
    endcase
    return c;
  endfunction

  // Speed divider tried at search position k
  function automatic logic [3:0] hs_try(input logic [2:0] k);
    logic [3:0] v;
    case (k)
      3'd0: v = 4'd11;
      3'd1: v = 4'd9;
      3'd2: v = 4'd7;
      3'd3: v = 4'd6;
      3'd4: v = 4'd5;
      default: v = 4'd4;
    endcase
    return v;
  endfunction

endpackage

/* rtl/odrc_if.sv */
// ----------------------------------------------------------------------------
// odrc_if: valid/ready channel
// Carries one beat of a generic payload between a source and a sink.
// ----------------------------------------------------------------------------
interface odrc_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/oscillator_divider_and_ratio_calc_core.sv */
// ----------------------------------------------------------------------------
// oscillator_divider_and_ratio_calc_core: oscillator divider and ratio calculator
// Picks new speed and output dividers and a new 38-bit ratio for a target.
// ----------------------------------------------------------------------------
// Usage: present one beat on the input channel (six control bytes and the
// requested frequency). The block works on one beat at a time; in_ready is
// high only while it is idle. The result beat is held in an output register
// until taken; a stalled receiver simply holds the block in its output
// state. Configuration (present frequency, oscillator limits) is written on
// the cfg_ port by the user only while idle; the block does not enforce it.
// Steps: two serial divisions for the divider bounds
// (DCO_W+FREQ_FRACTION_BITS+1 = 34 bits). The search then walks each speed
// divider tried for a total divider D by subtracting it step by step. After
// a hit: ratio x divider (the old divisor is formed alongside), then x f_new,
// then the 80-bit ratio division. The divider search sets the time; one
// beat is in flight at a time.
// Reset restores the default configuration and empties the block.
// ----------------------------------------------------------------------------
module oscillator_divider_and_ratio_calc_core #(
  parameter int FREQ_FRACTION_BITS = odrc_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  odrc_if.sink                           in_ch,
  odrc_if.source                         out_ch,
  input  logic                           cfg_we,
  input  logic [odrc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [odrc_pkg::CFG_W-1:0]     cfg_wdata
);
  import odrc_pkg::*;

  localparam int BW = DCO_W + FREQ_FRACTION_BITS + 1; // bound numerator width
  localparam int NUM_W = RATIO_W + 11 + FREQ_W;      // ratio numerator width
  localparam int DEN_W = FREQ_W + 11;                // ratio denominator width

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_HI   = 8'b0000_0010,
    S_LO   = 8'b0000_0100,
    S_SRCH = 8'b0000_1000,
    S_MUL1 = 8'b0001_0000,
    S_MUL2 = 8'b0010_0000,
    S_DIV  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [FREQ_W-1:0] cur_freq_r;
  logic [DCO_W-1:0]  dco_max_r, dco_min_r;

  logic [REG_W-1:0]  old_r, old_nxt;
  logic [FREQ_W-1:0] fnew_r, fnew_nxt;
  logic [10:0]       dv_r, dv_nxt, hi_r, hi_nxt;
  logic [2:0]        k_r, k_nxt;
  logic [10:0]       tmp_r, tmp_nxt;   // dv remainder walk
  logic [7:0]        n1c_r, n1c_nxt;
  logic [3:0]        hsn_r, hsn_nxt;
  logic [7:0]        n1n_r, n1n_nxt;
  logic [1:0]        st_r, st_nxt;
  logic [REG_W-1:0]  res_r, res_nxt;
  logic              ovr_r, ovr_nxt;   // low bound exceeds 1408

  // Shared bound divider
  logic          bd_start, bd_done, bd_big;
  logic [BW-1:0] bd_num;
  logic [BW-1:0] bd_quo;
  odrc_div #(.NW(BW), .DW(FREQ_W), .QW(BW)) u_bdiv (
    .clk, .rst_n, .start(bd_start), .num(bd_num), .den(fnew_r),
    .done(bd_done), .quo(bd_quo), .big(bd_big)
  );

  // Serial multipliers: ratio x (hs*n1) then x f_new; den via a third mult
  logic               m1_start, m1_done;
  logic [RATIO_W+10:0] m1_prod;
  odrc_mul #(.AW(RATIO_W), .BW(11)) u_mul1 (
    .clk, .rst_n, .start(m1_start), .a(old_r[RATIO_W-1:0]),
    .b(dv_r), .done(m1_done), .prod(m1_prod)
  );
  logic               m2_start, m2_done;
  logic [NUM_W-1:0]   m2_prod;
  odrc_mul #(.AW(RATIO_W + 11), .BW(FREQ_W)) u_mul2 (
    .clk, .rst_n, .start(m2_start), .a(m1_prod), .b(fnew_r),
    .done(m2_done), .prod(m2_prod)
  );
  logic               m3_done;
  logic [DEN_W-1:0]   m3_prod;
  logic [10:0]        old_div;
  assign old_div = 11'(hs_of_code(old_r[47:45])) * (11'(old_r[44:38]) + 11'd1);
  odrc_mul #(.AW(FREQ_W), .BW(11)) u_mul3 (
    .clk, .rst_n, .start(m1_start), .a(cur_freq_r), .b(old_div),
    .done(m3_done), .prod(m3_prod)
  );

  logic               rd_start, rd_done, rd_big;
  logic [RATIO_W-1:0] rd_quo;
  logic [DEN_W-1:0]   den_r;
  odrc_div #(.NW(NUM_W), .DW(DEN_W), .QW(RATIO_W)) u_rdiv (
    .clk, .rst_n, .start(rd_start), .num(m2_prod), .den(den_r),
    .done(rd_done), .quo(rd_quo), .big(rd_big)
  );

  // Hold configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_freq_r <= FREQ_W'(104857600);
      dco_max_r  <= DCO_W'(5670);
      dco_min_r  <= DCO_W'(4850);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CUR_FREQ: cur_freq_r <= cfg_wdata;
        CFG_DCO_MAX:  dco_max_r  <= cfg_wdata[DCO_W-1:0];
        CFG_DCO_MIN:  dco_min_r  <= cfg_wdata[DCO_W-1:0];
        default: ;
      endcase
    end
  end

  logic [3:0] hs_k;
  logic       n1_ok;
  assign hs_k  = hs_try(k_r);
  assign n1_ok = ((n1c_r == 8'd1) || !n1c_r[0]) && (n1c_r <= 8'd128);

  assign bd_num = (state_r == S_HI) ? BW'({dco_max_r, {FREQ_FRACTION_BITS{1'b0}}})
                : (BW'({dco_min_r, {FREQ_FRACTION_BITS{1'b0}}}) + BW'(fnew_r) - BW'(1));
  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.data  = {res_r, hsn_r, n1n_r, st_r};

  logic bd_go_r;

  // Sequence one beat: bounds, search, ratio
  always_comb begin
    state_nxt = state_r;
    old_nxt = old_r; fnew_nxt = fnew_r; dv_nxt = dv_r; hi_nxt = hi_r;
    k_nxt = k_r; tmp_nxt = tmp_r; n1c_nxt = n1c_r; hsn_nxt = hsn_r;
    n1n_nxt = n1n_r; st_nxt = st_r; res_nxt = res_r; ovr_nxt = ovr_r;
    bd_start = 1'b0; m1_start = 1'b0; m2_start = 1'b0; rd_start = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          old_nxt  = in_ch.data[REG_W+FREQ_W-1:FREQ_W];
          fnew_nxt = in_ch.data[FREQ_W-1:0];
          res_nxt  = in_ch.data[REG_W+FREQ_W-1:FREQ_W];
          hsn_nxt  = '0; n1n_nxt = '0; st_nxt = ST_NO_DIV;
          state_nxt = (in_ch.data[FREQ_W-1:0] == '0) ? S_OUT : S_HI;
        end
      end
      S_HI: begin
        bd_start = !bd_go_r;
        if (bd_done) begin
          hi_nxt = (bd_quo > BW'(MAX_TOTAL_DIV)) ? MAX_TOTAL_DIV : bd_quo[10:0];
          state_nxt = S_LO;
        end
      end
      S_LO: begin
        bd_start = !bd_go_r;
        if (bd_done) begin
          ovr_nxt = (bd_quo > BW'(MAX_TOTAL_DIV));
          dv_nxt  = (bd_quo == '0) ? 11'd1 : bd_quo[10:0];
          k_nxt = '0; tmp_nxt = '0; n1c_nxt = '0;
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        // Walk dv by subtraction of hs: one step per cycle
        if (ovr_r || dv_r > hi_r) begin
          state_nxt = S_OUT;
        end else if (tmp_r + 11'(hs_k) <= dv_r) begin
          tmp_nxt = tmp_r + 11'(hs_k);
          n1c_nxt = (n1c_r == 8'd255) ? n1c_r : n1c_r + 8'd1;
        end else if (tmp_r == dv_r && n1_ok) begin
          hsn_nxt = hs_k; n1n_nxt = n1c_r;
          dv_nxt  = dv_r;
          state_nxt = S_MUL1;
        end else begin
          tmp_nxt = '0; n1c_nxt = '0;
          if (k_r == 3'd5) begin
            k_nxt = '0; dv_nxt = dv_r + 11'd1;
          end else begin
            k_nxt = k_r + 3'd1;
          end
        end
      end
      S_MUL1: begin
        m1_start = !bd_go_r;
        if (m1_done) begin
          m2_start = 1'b1;
          state_nxt = S_MUL2;
        end
      end
      S_MUL2: begin
        if (m2_done) begin
          if (den_r == '0) begin
            st_nxt = ST_OVERFLOW; state_nxt = S_OUT;
          end else begin
            rd_start = 1'b1; state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (rd_done) begin
          if (rd_big) begin
            st_nxt = ST_OVERFLOW;
          end else begin
            st_nxt  = ST_OK;
            res_nxt = {code_of_hs(hsn_r), 7'(n1n_r - 8'd1), rd_quo};
          end
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ch.ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      bd_go_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      bd_go_r   <= (state_nxt == state_r) &&
                   (state_r == S_HI || state_r == S_LO || state_r == S_MUL1);
    end
    old_r <= old_nxt; fnew_r <= fnew_nxt; dv_r <= dv_nxt; hi_r <= hi_nxt;
    k_r <= k_nxt; tmp_r <= tmp_nxt; n1c_r <= n1c_nxt; hsn_r <= hsn_nxt;
    n1n_r <= n1n_nxt; st_r <= st_nxt; res_r <= res_nxt; ovr_r <= ovr_nxt;
    if (m3_done) den_r <= m3_prod;
  end

endmodule

/* rtl/odrc_div.sv */
// ----------------------------------------------------------------------------
// odrc_div: bit-serial restoring divider
// Shifts one numerator bit per cycle into the remainder, top bit first.
// ----------------------------------------------------------------------------
module odrc_div #(
  parameter int NW = 16,
  parameter int DW = 16,
  parameter int QW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [QW-1:0] quo,
  output logic          big
);
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] num_r, num_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [QW-1:0] quo_r, quo_nxt;
  logic          big_r, big_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   sh;
  logic          ge;

  assign sh = {rem_r[DW-1:0], num_r[NW-1]};
  assign ge = (sh >= {1'b0, den});

  // Advance one quotient bit per cycle
  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    big_nxt  = big_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt  = num;
      rem_nxt  = '0;
      quo_nxt  = '0;
      big_nxt  = 1'b0;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[NW-2:0], 1'b0};
      rem_nxt = ge ? (sh - {1'b0, den}) : sh;
      quo_nxt = {quo_r[QW-2:0], ge};
      if (ge && (cnt_r > CW'(QW))) big_nxt = 1'b1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    big_r <= big_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign big  = big_r;
endmodule

/* rtl/odrc_mul.sv */
// ----------------------------------------------------------------------------
// odrc_mul: bit-serial shift-add multiplier
// Consumes one multiplier bit per cycle, low bit first.
// ----------------------------------------------------------------------------
module odrc_mul #(
  parameter int AW = 16,
  parameter int BW = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic             done,
  output logic [AW+BW-1:0] prod
);
  localparam int PW = AW + BW;
  localparam int CW = $clog2(BW + 1);

  logic [PW-1:0] acc_r, acc_nxt;
  logic [PW-1:0] a_r, a_nxt;
  logic [BW-1:0] b_r, b_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;

  // Add the shifted multiplicand where the multiplier bit is set
  always_comb begin
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = '0;
      a_nxt    = PW'(a);
      b_nxt    = b;
      cnt_nxt  = CW'(BW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (b_r[0]) acc_nxt = acc_r + a_r;
      a_nxt   = {a_r[PW-2:0], 1'b0};
      b_nxt   = b_r >> 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;
endmodule

/* sim/oscillator_divider_and_ratio_calc_core_tb.sv */
// ----------------------------------------------------------------------------
// oscillator_divider_and_ratio_calc_core_tb: self-checking bench of the core
// Sends control bytes and target frequencies through the valid/ready input
// channel under several limit and frequency settings. An internal predictor
// works out the new dividers, ratio and status of each beat. A monitor checks
// every result beat, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module oscillator_divider_and_ratio_calc_core_tb;
  import odrc_pkg::*;

  localparam int IN_W     = REG_W + FREQ_W;
  localparam int OUT_W    = REG_W + 4 + 8 + 2;
  localparam int FRAC     = FRAC_BITS_DEF;
  localparam int IDLE_LIM = 150000;
  localparam int LONG_HOLD = 3000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [REG_W-1:0] regs;
    logic [3:0]       hs;
    logic [7:0]       n1;
    logic [1:0]       st;
  } settings_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_CUR_FREQ;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  odrc_if #(IN_W)  in_ch();
  odrc_if #(OUT_W) out_ch();

  oscillator_divider_and_ratio_calc_core u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Shadow configuration
  logic [FREQ_W-1:0] cur_freq = 31'd104857600;
  logic [DCO_W-1:0]  dco_hi = 13'd5670;
  logic [DCO_W-1:0]  dco_lo = 13'd4850;

  settings_t expected_q[$];
  int  errors = 0;
  bit  quiet = 1'b0;
  bit  hold_req = 1'b0;
  int  idle_cycles = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Register code of a speed divider value
  function automatic logic [2:0] speed_code(input logic [3:0] v);
    case (v)
      4'd5:    return 3'd1;
      4'd6:    return 3'd2;
      4'd7:    return 3'd3;
      4'd9:    return 3'd5;
      4'd11:   return 3'd7;
      default: return 3'd0;
    endcase
  endfunction

  // Work out the new dividers and ratio for one request
  function automatic settings_t predict_settings(input logic [REG_W-1:0] old,
                                                 input logic [FREQ_W-1:0] fnew);
    settings_t r;
    logic [3:0] order [6] = '{4'd11, 4'd9, 4'd7, 4'd6, 4'd5, 4'd4};
    logic [3:0] hs_old;
    logic [7:0] n1_old;
    logic [127:0] num, den, q;
    longint unsigned hi_d, lo_d, dv, hs_c, n1_c;
    bit found;
    r = '{old, 4'd0, 8'd0, ST_NO_DIV};
    if (fnew == 0) return r;
    case (old[47:45])
      3'd1: hs_old = 4'd5;
      3'd2, 3'd6: hs_old = 4'd6;
      3'd3: hs_old = 4'd7;
      3'd5: hs_old = 4'd9;
      3'd7: hs_old = 4'd11;
      default: hs_old = 4'd4;
    endcase
    n1_old = {1'b0, old[44:38]} + 8'd1;
    hi_d = (64'(dco_hi) << FRAC) / 64'(fnew);
    lo_d = ((64'(dco_lo) << FRAC) + 64'(fnew) - 1) / 64'(fnew);
    if (lo_d < 1) lo_d = 1;
    if (hi_d > 1408) hi_d = 1408;
    found = 1'b0;
    hs_c = 0;
    n1_c = 0;
    for (dv = lo_d; dv <= hi_d && !found; dv++) begin
      for (int k = 0; k < 6 && !found; k++) begin
        if (dv % order[k] == 0) begin
          n1_c = dv / order[k];
          if ((n1_c == 1 || n1_c[0] == 1'b0) && n1_c <= 128) begin
            hs_c = order[k];
            found = 1'b1;
          end
        end
      end
    end
    if (!found) return r;
    r.hs = hs_c[3:0];
    r.n1 = n1_c[7:0];
    num = 128'(old[37:0]) * 128'(hs_c * n1_c) * 128'(fnew);
    den = 128'(cur_freq) * 128'(hs_old) * 128'(n1_old);
    if (den == 0) begin
      r.st = ST_OVERFLOW;
      return r;
    end
    q = num / den;
    if (q >= (128'd1 << RATIO_W)) begin
      r.st = ST_OVERFLOW;
      return r;
    end
    r.regs = {speed_code(r.hs), 7'(n1_c - 1), q[37:0]};
    r.st = ST_OK;
    return r;
  endfunction

  // Offer one beat; valid stays high between back-to-back beats but for random gaps while not quiet
  task automatic send_request(input logic [REG_W-1:0] old, input logic [FREQ_W-1:0] fnew);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= {old, fnew};
    do @(posedge clk); while (!in_ch.ready);
    expected_q.push_back(predict_settings(old, fnew));
  endtask

  // Drop valid and wait until every result is back
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Write one register once nothing is in flight
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_CUR_FREQ: cur_freq = val;
      CFG_DCO_MAX:  dco_hi = val[DCO_W-1:0];
      CFG_DCO_MIN:  dco_lo = val[DCO_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [REG_W-1:0] rand_regs();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [FREQ_W-1:0] rand_freq();
    case ($urandom_range(0, 9))
      0, 1:    return 31'($urandom);
      2, 3:    return 31'($urandom_range(10, 1500)) << FRAC;
      default: return 31'($urandom_range(10485760, 1572864000));
    endcase
  endfunction

  // Directed: field extremes, speed codes, zero frequency, default limits
  task automatic test_defaults();
    send_request(48'h0, 31'd104857600);
    send_request(48'hFFFF_FFFF_FFFF, 31'd104857600);
    send_request(48'h01C2_D3E4_F506, 31'd0);
    send_request(48'h07C0_0000_0000, 31'h7FFF_FFFF);
    send_request(48'h07C0_0000_0000, 31'd10485760);
    send_request(48'h07C0_0000_0000, 31'd1572864000);
    for (int c = 0; c < 8; c++)
      send_request({3'(c), 7'd5, 38'h2B_0000_0000}, 31'(156 << FRAC));
    drain();
  endtask

  // Directed: limits and present frequency at their extremes
  task automatic test_config_extremes();
    write_reg(CFG_DCO_MAX, 31'd8191);
    write_reg(CFG_DCO_MIN, 31'd1);
    write_reg(CFG_CUR_FREQ, 31'd10485760);
    send_request(48'h0000_0000_0001, 31'd10485760);
    send_request(48'hE03F_FFFF_FFFF, 31'd1572864000);
    write_reg(CFG_CUR_FREQ, 31'd1572864000);
    write_reg(CFG_DCO_MAX, 31'd1);
    send_request(48'h2000_0000_0000, 31'd10485760);
    write_reg(CFG_DCO_MAX, 31'd8191);
    write_reg(CFG_DCO_MIN, 31'd8191);
    send_request(rand_regs(), 31'(5 << FRAC));
    write_reg(CFG_SPARE, 31'h7FFF_FFFF);
    send_request(rand_regs(), 31'(100 << FRAC));
    drain();
  endtask

  // Directed: zero present frequency gives a zero divisor
  task automatic test_zero_current();
    write_reg(CFG_CUR_FREQ, 31'd0);
    write_reg(CFG_DCO_MAX, 31'd5670);
    write_reg(CFG_DCO_MIN, 31'd4850);
    send_request(48'h0000_1234_5678, 31'd104857600);
    send_request(48'h0, 31'd104857600);
    drain();
    write_reg(CFG_CUR_FREQ, 31'd104857600);
  endtask

  // Hold the receiver off while beats keep coming
  task automatic test_pressure();
    hold_req = 1'b1;
    for (int i = 0; i < 6; i++) send_request(rand_regs(), rand_freq());
    drain();
  endtask

  task automatic test_random(input int n, input bit new_cfg);
    if (new_cfg) begin
      write_reg(CFG_CUR_FREQ, $urandom_range(0, 3) == 0 ? 31'($urandom)
                                : 31'($urandom_range(10485760, 1572864000)));
      write_reg(CFG_DCO_MAX, 31'($urandom_range(3000, 8191)));
      write_reg(CFG_DCO_MIN, 31'($urandom_range(1, 6000)));
    end
    for (int i = 0; i < n; i++) send_request(rand_regs(), rand_freq());
    drain();
  endtask

  // Receiver: random stall bursts and one long hold-off
  always @(posedge clk) begin
    static int stall_left = 0;
    if (hold_req) begin
      hold_req = 1'b0;
      stall_left = LONG_HOLD;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 10);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Check each result beat against the oldest prediction
  always @(posedge clk) begin
    settings_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected: %h", got);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got.regs !== want.regs) begin
          $error("new_registers expected %h got %h", want.regs, got.regs);
          errors++;
        end
        if (got.hs !== want.hs) begin
          $error("speed_divider expected %0d got %0d", want.hs, got.hs);
          errors++;
        end
        if (got.n1 !== want.n1) begin
          $error("output_divider expected %0d got %0d", want.n1, got.n1);
          errors++;
        end
        if (got.st !== want.st) begin
          $error("status expected %0d got %0d", want.st, got.st);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIM) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_config_extremes();
    test_zero_current();
    test_pressure();
    test_random(15, 1'b0);
    test_random(25, 1'b1);
    test_random(25, 1'b1);
    test_random(25, 1'b1);
    quiet = 1'b1;
    test_random(25, 1'b1);
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
